// ----- rtl/core/scbc_pkg.sv -----
// shared types, register codes and constants for the sample consensus classifier
`timescale 1ns / 1ps
`default_nettype none

package scbc_pkg;

	// item field widths
	localparam int PIX_W   = 14;
	localparam int SLOT_W  = 4;
	localparam int COLOR_W = 8;
	localparam int THR_W   = 10;
	localparam int SMP_W   = 3 * COLOR_W;

	// configuration register widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int REQ_W      = 7;
	localparam int RATE_W     = 6;

	// threshold format: unsigned Q4.6
	localparam int FRAC_BITS = 6;
	localparam logic [THR_W-1:0] THR_RESET = 10'd960;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd4;

	// configuration reset values
	localparam logic [COLOR_W-1:0] LIMIT0_RESET   = 8'd10;
	localparam logic [COLOR_W-1:0] LIMIT1_RESET   = 8'd5;
	localparam logic [COLOR_W-1:0] LIMIT2_RESET   = 8'd5;
	localparam logic [REQ_W-1:0]   REQUIRED_RESET = 7'd2;
	localparam logic [RATE_W-1:0]  RATE_RESET     = 6'd3;

	// item commands
	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_WRITE    = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic dispatch;
		logic walk_start;
		logic walk_step;
		logic blend;
		logic finish;
	} scbc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic classify_go;
		logic walk_end;
	} scbc_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/scbc_item_if.sv -----
// input word channel: valid/ready handshake with the classify or write item
`timescale 1ns / 1ps
`default_nettype none

interface scbc_item_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [scbc_pkg::PIX_W-1:0]       pixel_index;
	logic [scbc_pkg::SLOT_W-1:0]      sample_slot;
	logic [scbc_pkg::COLOR_W-1:0]     color_ch0;
	logic [scbc_pkg::COLOR_W-1:0]     color_ch1;
	logic [scbc_pkg::COLOR_W-1:0]     color_ch2;
	logic                             in_roi;

	modport source (
		output valid, cmd, pixel_index, sample_slot, color_ch0, color_ch1, color_ch2, in_roi,
		input  ready
	);

	modport sink (
		input  valid, cmd, pixel_index, sample_slot, color_ch0, color_ch1, color_ch2, in_roi,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/scbc_result_if.sv -----
// result word channel: valid/ready handshake with the classification result
`timescale 1ns / 1ps
`default_nettype none

interface scbc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         foreground;
	logic [scbc_pkg::THR_W-1:0]   min_distance;
	logic [scbc_pkg::THR_W-1:0]   new_threshold;

	modport source (
		output valid, foreground, min_distance, new_threshold,
		input  ready
	);

	modport sink (
		input  valid, foreground, min_distance, new_threshold,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/sample_consensus_background_classifier_core.sv -----
// top level of the per-pixel sample consensus background classifier
//
//  channel   dir   handshake        word contents
//  -------   ---   --------------   ----------------------------------------------------
//  item      in    valid / ready    cmd, pixel_index, sample_slot, color_ch0..2, in_roi
//  result    out   valid / ready    foreground, min_distance, new_threshold
//  cfg       in    cfg_we only      cfg_index, cfg_wdata (no read-back)
//
//  a classify word goes from acceptance through dispatch, threshold read, the walk, blend
//  and finish before the next acceptance; one sample store read per cycle sets the walk,
//  which ends early once enough samples match
//  a write word, a skipped pixel or an out-of-range index goes through dispatch and finish
//  after reset the threshold store is swept to 15.0, one entry a cycle;
//  item.ready stays low during the sweep while cfg writes are taken
//  a finished word waits in the result register; a stalled result only holds back
//  the final hand-off, the next item word is taken as soon as the block is idle
`timescale 1ns / 1ps
`default_nettype none

module sample_consensus_background_classifier_core #(
	parameter int SAMPLES = 16,
	parameter int PIXELS  = 16384
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [scbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [scbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	scbc_item_if.sink                               item,
	scbc_result_if.source                           result
);

	// command and status bundles between controller and datapath
	scbc_pkg::scbc_cmd_t    cmd;
	scbc_pkg::scbc_status_t status;

	// controller: sequencing and both handshakes
	scbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: stores, sample compare, blend and result register
	scbc_dpath #(
		.SAMPLES (SAMPLES),
		.PIXELS  (PIXELS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.item_cmd          (item.cmd),
		.item_pixel_index  (item.pixel_index),
		.item_sample_slot  (item.sample_slot),
		.item_color_ch0    (item.color_ch0),
		.item_color_ch1    (item.color_ch1),
		.item_color_ch2    (item.color_ch2),
		.item_in_roi       (item.in_roi),
		.res_foreground    (result.foreground),
		.res_min_distance  (result.min_distance),
		.res_new_threshold (result.new_threshold),
		.cmd               (cmd),
		.status            (status)
	);

endmodule

`default_nettype wire

// ----- rtl/core/scbc_ram.sv -----
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module scbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/scbc_ctrl.sv -----
// controller state machine: clearing pass, item dispatch, sample walk, result hand-off
`timescale 1ns / 1ps
`default_nettype none

module scbc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire scbc_pkg::scbc_status_t status,
	output scbc_pkg::scbc_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_THR,
		ST_WALK,
		ST_BLEND,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.clr_step   = (state_q == ST_CLEAR);
		cmd.load_item  = (state_q == ST_IDLE) && in_valid;
		cmd.dispatch   = (state_q == ST_DISPATCH);
		cmd.walk_start = (state_q == ST_THR);
		cmd.walk_step  = (state_q == ST_WALK);
		cmd.blend      = (state_q == ST_BLEND);
		cmd.finish     = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// a new result word replaces the one leaving in this cycle
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					state_q <= status.classify_go ? ST_THR : ST_FINISH;
				end
				ST_THR: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (status.walk_end) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/scbc_dpath.sv -----
// datapath: config registers, sample and threshold stores, match compare and blend
`timescale 1ns / 1ps
`default_nettype none

module scbc_dpath #(
	parameter int SAMPLES = 16,
	parameter int PIXELS  = 16384
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration
	input  wire logic                                   cfg_we,
	input  wire logic [scbc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [scbc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	// item payload
	input  wire logic                                   item_cmd,
	input  wire logic [scbc_pkg::PIX_W-1:0]             item_pixel_index,
	input  wire logic [scbc_pkg::SLOT_W-1:0]            item_sample_slot,
	input  wire logic [scbc_pkg::COLOR_W-1:0]           item_color_ch0,
	input  wire logic [scbc_pkg::COLOR_W-1:0]           item_color_ch1,
	input  wire logic [scbc_pkg::COLOR_W-1:0]           item_color_ch2,
	input  wire logic                                   item_in_roi,
	// result payload
	output logic                                        res_foreground,
	output logic      [scbc_pkg::THR_W-1:0]             res_min_distance,
	output logic      [scbc_pkg::THR_W-1:0]             res_new_threshold,
	// control
	input  wire scbc_pkg::scbc_cmd_t                    cmd,
	output scbc_pkg::scbc_status_t                      status
);

	localparam int PIXW   = scbc_pkg::PIX_W;
	localparam int SLW    = scbc_pkg::SLOT_W;
	localparam int CW     = scbc_pkg::COLOR_W;
	localparam int TW     = scbc_pkg::THR_W;
	localparam int RQW    = scbc_pkg::REQ_W;
	localparam int RTW    = scbc_pkg::RATE_W;
	localparam int FB     = scbc_pkg::FRAC_BITS;
	localparam int PA_W   = $clog2(PIXELS);
	localparam int SW     = $clog2(SAMPLES);
	localparam int IDX_W  = $clog2(SAMPLES + 1);
	localparam int SDEPTH = PIXELS * (2 ** SW);
	localparam int SA_W   = PA_W + SW;
	localparam int KW     = RTW + 3;            // 256 - rate
	localparam int BW     = TW + KW;            // blend sum width
	localparam int DSW    = CW + 2;             // summed l1 distance

	// configuration registers
	logic [CW-1:0]  lim0_q, lim1_q, lim2_q;
	logic [RQW-1:0] required_q;
	logic [RTW-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim0_q     <= scbc_pkg::LIMIT0_RESET;
			lim1_q     <= scbc_pkg::LIMIT1_RESET;
			lim2_q     <= scbc_pkg::LIMIT2_RESET;
			required_q <= scbc_pkg::REQUIRED_RESET;
			rate_q     <= scbc_pkg::RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scbc_pkg::REG_LIMIT0:   lim0_q     <= cfg_wdata;
				scbc_pkg::REG_LIMIT1:   lim1_q     <= cfg_wdata;
				scbc_pkg::REG_LIMIT2:   lim2_q     <= cfg_wdata;
				scbc_pkg::REG_REQUIRED: required_q <= cfg_wdata[RQW-1:0];
				scbc_pkg::REG_RATE:     rate_q     <= cfg_wdata[RTW-1:0];
				default: ;
			endcase
		end
	end

	// item registers
	logic          cmd_q;
	logic [PIXW-1:0] pix_q;
	logic [SLW-1:0]  slot_q;
	logic [CW-1:0]   c0_q, c1_q, c2_q;
	logic            roi_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= item_cmd;
			pix_q  <= item_pixel_index;
			slot_q <= item_sample_slot;
			c0_q   <= item_color_ch0;
			c1_q   <= item_color_ch1;
			c2_q   <= item_color_ch2;
			roi_q  <= item_in_roi;
		end
	end

	// address forming and range checks
	logic [PIXW+PA_W-1:0] pix_wide;
	logic [SLW+SW-1:0]    slot_wide;
	logic [PA_W-1:0]      pix_addr;
	logic                 pix_ok, slot_ok, classify_go, smp_wr;

	assign pix_wide    = {{PA_W{1'b0}}, pix_q};
	assign slot_wide   = {{SW{1'b0}}, slot_q};
	assign pix_addr    = pix_wide[PA_W-1:0];
	assign pix_ok      = pix_wide < (PIXW+PA_W)'(PIXELS);
	assign slot_ok     = slot_wide < (SLW+SW)'(SAMPLES);
	assign classify_go = pix_ok && (cmd_q == scbc_pkg::CMD_CLASSIFY) && roi_q;
	assign smp_wr      = cmd.dispatch && pix_ok && (cmd_q == scbc_pkg::CMD_WRITE) && slot_ok;

	// clearing pass over the threshold store
	logic [PA_W-1:0] clr_addr_q;
	logic            clr_last;

	assign clr_last = (clr_addr_q == PA_W'(PIXELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step && !clr_last) begin
			clr_addr_q <= clr_addr_q + PA_W'(1);
		end
	end

	// sample walk state
	logic [IDX_W-1:0] rd_idx_q;
	logic             cmp_valid_s1;
	logic [RQW-1:0]   count_q;
	logic [TW-1:0]    dmin_q;
	logic [TW-1:0]    thr_q;
	logic [TW-1:0]    blend_s1;
	logic             all_issued, enough, walk_end, smp_rd;

	assign all_issued = (rd_idx_q == IDX_W'(SAMPLES));
	assign enough     = (count_q >= required_q);
	assign walk_end   = enough || (all_issued && cmp_valid_s1);
	assign smp_rd     = (cmd.walk_start || (cmd.walk_step && !walk_end)) && !all_issued;

	// memories
	logic [SA_W-1:0]              smp_waddr, smp_raddr;
	logic [scbc_pkg::SMP_W-1:0]   smp_wdata, smp_rdata;
	logic                         thr_we;
	logic [PA_W-1:0]              thr_waddr;
	logic [TW-1:0]                thr_wdata, thr_rdata;

	assign smp_waddr = {pix_addr, slot_wide[SW-1:0]};
	assign smp_raddr = {pix_addr, rd_idx_q[SW-1:0]};
	assign smp_wdata = {c2_q, c1_q, c0_q};

	scbc_ram #(
		.WIDTH (scbc_pkg::SMP_W),
		.DEPTH (SDEPTH)
	) u_smp_ram (
		.clk   (clk),
		.we    (smp_wr),
		.waddr (smp_waddr),
		.wdata (smp_wdata),
		.re    (smp_rd),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	logic fg_w;
	assign fg_w = (count_q < required_q);

	assign thr_we    = cmd.clr_step || (cmd.finish && classify_go && !fg_w);
	assign thr_waddr = cmd.clr_step ? clr_addr_q : pix_addr;
	assign thr_wdata = cmd.clr_step ? scbc_pkg::THR_RESET : blend_s1;

	scbc_ram #(
		.WIDTH (TW),
		.DEPTH (PIXELS)
	) u_thr_ram (
		.clk   (clk),
		.we    (thr_we),
		.waddr (thr_waddr),
		.wdata (thr_wdata),
		.re    (cmd.dispatch && classify_go),
		.raddr (pix_addr),
		.rdata (thr_rdata)
	);

	// per-sample compare
	function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CW-1:0]  d0, d1, d2;
	logic [DSW-1:0] dsum;
	logic [TW-1:0]  dsum_q46;
	logic           match;

	assign d0       = absdiff(c0_q, smp_rdata[CW-1:0]);
	assign d1       = absdiff(c1_q, smp_rdata[2*CW-1:CW]);
	assign d2       = absdiff(c2_q, smp_rdata[3*CW-1:2*CW]);
	assign dsum     = DSW'(d0) + DSW'(d1) + DSW'(d2);
	// a counted match is at most 15, so four integer bits suffice
	assign dsum_q46 = {dsum[TW-FB-1:0], {FB{1'b0}}};
	assign match    = (d0 <= lim0_q) && (d1 <= lim1_q) && (d2 <= lim2_q)
	                  && (dsum <= DSW'(thr_q[TW-1:FB]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			cmp_valid_s1 <= smp_rd;
			if (cmd.load_item) begin
				rd_idx_q <= '0;
			end else if (smp_rd) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			thr_q   <= thr_rdata;
			dmin_q  <= thr_rdata;
			count_q <= '0;
		end else if (cmd.walk_step && cmp_valid_s1 && !enough && match) begin
			count_q <= count_q + RQW'(1);
			if (dmin_q > dsum_q46) begin
				dmin_q <= dsum_q46;
			end
		end
	end

	// threshold blend: (thr * (256 - rate) + rate * dmin) >> 8
	logic [KW-1:0] keep_w;
	logic [BW-1:0] prod_keep, prod_rate, blend_sum;

	assign keep_w    = KW'(256) - KW'(rate_q);
	assign prod_keep = BW'(thr_q) * BW'(keep_w);
	assign prod_rate = BW'(dmin_q) * BW'(rate_q);
	assign blend_sum = prod_keep + prod_rate;

	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			blend_s1 <= blend_sum[TW+7:8];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (classify_go) begin
				res_foreground    <= fg_w;
				res_min_distance  <= dmin_q;
				res_new_threshold <= fg_w ? thr_q : blend_s1;
			end else begin
				res_foreground    <= 1'b0;
				res_min_distance  <= '0;
				res_new_threshold <= '0;
			end
		end
	end

	always_comb begin
		status             = '0;
		status.clr_last    = clr_last;
		status.classify_go = classify_go;
		status.walk_end    = walk_end;
	end

endmodule

`default_nettype wire

// ----- rtl/core/scbc_checker.sv -----
// port-level checks for the classifier core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module scbc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             item_valid,
	input wire logic                             item_ready,
	input wire logic                             result_valid,
	input wire logic                             result_ready,
	input wire logic                             result_foreground,
	input wire logic [scbc_pkg::THR_W-1:0]       result_min_distance,
	input wire logic [scbc_pkg::THR_W-1:0]       result_new_threshold
);

	// a stalled result word holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
		&& $stable(result_foreground) && $stable(result_min_distance)
		&& $stable(result_new_threshold))
	else $error("stalled result word changed");

	// one word in flight: acceptance drops ready on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
	else $error("item taken while another is in work");

	// the blended threshold never falls below the reported minimum distance
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_min_distance <= result_new_threshold)
	else $error("min_distance above new_threshold");

	// thresholds stay within 15.0
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_new_threshold <= scbc_pkg::THR_RESET)
	else $error("new_threshold above 15.0");

endmodule

bind sample_consensus_background_classifier_core scbc_checker u_scbc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.item_valid           (item.valid),
	.item_ready           (item.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_foreground    (result.foreground),
	.result_min_distance  (result.min_distance),
	.result_new_threshold (result.new_threshold)
);

`default_nettype wire
